FILE: src/ffts_pkg.sv
// ffts_pkg: shared types and codes for the fault fixup table search block.
// No dependencies; imported by ffts_mem, ffts_alu and fault_fixup_table_search.
package ffts_pkg;

    localparam int ADDR_W = 64;
    localparam int OFFSET_W = 62;
    localparam int SLOTS_W = 9;
    localparam int INDEX_W = 8;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic               action;
        logic [INDEX_W-1:0] slot_index;
        logic [ADDR_W-1:0]  slot_insn;
        logic [ADDR_W-1:0]  slot_fixup;
        logic [ADDR_W-1:0]  lookup_addr;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [ADDR_W-1:0]   fixup_addr;
        logic                range_hit;
        logic [OFFSET_W-1:0] insn_offset;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] insn;
        logic [ADDR_W-1:0] fixup;
    } t_slot;

    typedef struct packed {
        logic              eq;
        logic              lt;
        logic [ADDR_W-1:0] diff;
    } t_alu_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXACT,
        ST_RANGE_LO,
        ST_RANGE_HI,
        ST_OFFSET,
        ST_FINISH
    } t_state;

endpackage

FILE: src/ffts_mem.sv
// ffts_mem: slot table, one write port and one registered read port.
// Depends on ffts_pkg (t_slot).
module ffts_mem
    import ffts_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ffts_alu.sv
// ffts_alu: shared 64-bit subtract / compare unit used by every scan step.
// Depends on ffts_pkg (t_alu_res).
module ffts_alu
    import ffts_pkg::*;
(
    input  logic [ADDR_W-1:0] i_a,
    input  logic [ADDR_W-1:0] i_b,
    output t_alu_res          o_res
);

    logic [ADDR_W:0] sub;

    // borrow out of a - b means a < b
    assign sub = {1'b0, i_a} - {1'b0, i_b};

    always_comb begin
        o_res.eq   = (i_a == i_b);
        o_res.lt   = sub[ADDR_W];
        o_res.diff = sub[ADDR_W-1:0];
    end

endmodule

FILE: src/fault_fixup_table_search.sv
// fault_fixup_table_search: top level, lookup sequencer and result register.
// Depends on ffts_pkg, ffts_mem (slot table) and ffts_alu (shared compare unit).
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+------------------------
//  in       | into      | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out      | out of    | o_out_valid/ i_out_stall| o_out_data (t_out_item)
//  cfg      | into      | i_cfg_we                | i_cfg_data (slots_in_use)
//
// A load transfer leaves the block in the idle state, ready for the next item.
// A lookup stalls the input through the exact scan, which steps over single
// slots one at a time and over range pairs whole; then, unless that scan hits,
// through the range scan, which visits each range start before its end; then
// the offset state on a range hit and the finish state. The scan is paced by
// the single one-slot-per-cycle read port of the slot table.
// Reset (synchronous, active low) clears the sequencer, the output valid
// and slots_in_use; the table itself is not cleared and needs no sweep.
// The finished result sits in an output register: a stalled output only
// holds the block in the finish state if a second result is ready.
module fault_fixup_table_search
    import ffts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [SLOTS_W-1:0] i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    // scan index must hold depth + 1
    localparam int CW = $clog2(TABLE_DEPTH + 2);
    localparam int IW = (CW > SLOTS_W) ? CW : SLOTS_W;
    localparam logic [IW-1:0] DEPTH_W = IW'(TABLE_DEPTH);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [ADDR_W-1:0]  r_start, n_start;
    logic               r_ge, n_ge;
    t_out_item          r_res, n_res;
    t_out_item          r_out;
    logic               r_out_valid, n_out_valid;
    logic               n_out_load;
    logic [SLOTS_W-1:0] r_slots;

    logic               in_xfer;
    logic               idx_ok;
    logic               mem_we;
    t_slot              wslot;
    t_slot              rslot;
    logic [ADDR_W-1:0]  alu_b;
    t_alu_res           alu;
    logic [CW-1:0]      cnt_clip;
    logic [CW-1:0]      idx_p1;
    logic [CW-1:0]      idx_p2;

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // loads past the table end are dropped
    assign idx_ok = (IW'(i_in_data.slot_index) < DEPTH_W);
    assign mem_we = in_xfer && (i_in_data.action == ACT_LOAD) && idx_ok;

    always_comb begin
        wslot.insn  = i_in_data.slot_insn;
        wslot.fixup = i_in_data.slot_fixup;
    end

    // slot count searched is clipped to the table depth
    assign cnt_clip = (IW'(r_slots) > DEPTH_W) ? CW'(TABLE_DEPTH) : CW'(r_slots);

    assign idx_p1 = r_idx + CW'(1);
    assign idx_p2 = r_idx + CW'(2);

    // ---------------------------------------------------------------
    // slot table and shared compare unit
    // ---------------------------------------------------------------
    ffts_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(i_in_data.slot_index)),
        .i_wdata (wslot),
        .i_raddr (n_idx[AW-1:0]),
        .o_rdata (rslot)
    );

    // a is always the lookup address; b is the slot address, or the
    // range start when the word offset is formed
    assign alu_b = (r_state == ST_OFFSET) ? r_start : rslot.insn;

    ffts_alu u_alu (
        .i_a   (r_addr),
        .i_b   (alu_b),
        .o_res (alu)
    );

    // ---------------------------------------------------------------
    // sequencer
    // rslot always holds the slot at r_idx; the read address is n_idx,
    // so each scan step moves on by one slot, or by a whole range pair in the exact scan.
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_start     = r_start;
        n_ge        = r_ge;
        n_res       = r_res;
        n_out_load  = 1'b0;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (in_xfer && (i_in_data.action == ACT_LOOKUP)) begin
                    n_addr  = i_in_data.lookup_addr;
                    n_cnt   = cnt_clip;
                    n_res   = '0;
                    n_state = ST_EXACT;
                end
            end

            ST_EXACT: begin
                if (r_idx >= r_cnt) begin
                    // no single-instruction hit: start the range walk
                    n_idx   = '0;
                    n_state = ST_RANGE_LO;
                end else if (rslot.fixup == '0) begin
                    n_idx = idx_p2;
                end else if (alu.eq) begin
                    n_res.found      = 1'b1;
                    n_res.fixup_addr = rslot.fixup;
                    n_state          = ST_FINISH;
                end else begin
                    n_idx = idx_p1;
                end
            end

            ST_RANGE_LO: begin
                if (idx_p1 >= r_cnt) begin
                    // nothing matched; result stays all zero
                    n_state = ST_FINISH;
                end else if (rslot.fixup != '0) begin
                    n_idx = idx_p1;
                end else begin
                    n_start = rslot.insn;
                    n_ge    = !alu.lt;
                    n_idx   = idx_p1;
                    n_state = ST_RANGE_HI;
                end
            end

            ST_RANGE_HI: begin
                // rslot is the range end slot
                if (r_ge && alu.lt) begin
                    n_res.found      = (rslot.fixup != '0);
                    n_res.fixup_addr = rslot.fixup;
                    n_res.range_hit  = 1'b1;
                    n_state          = ST_OFFSET;
                end else begin
                    n_idx   = idx_p1;
                    n_state = ST_RANGE_LO;
                end
            end

            ST_OFFSET: begin
                n_res.insn_offset = alu.diff[ADDR_W-1:2];
                n_state           = ST_FINISH;
            end

            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_slots     <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_slots <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_start <= n_start;
        r_ge    <= n_ge;
        r_res   <= n_res;
        if (n_out_load) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_found_vs_fixup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.found == (o_out_data.fixup_addr != '0)))
        else $error("found flag disagrees with fixup address");

    a_offset_only_on_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.range_hit) |-> (o_out_data.insn_offset == '0))
        else $error("nonzero offset without a range hit");

    a_lookup_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.action == ACT_LOOKUP)) |=> (r_state == ST_EXACT))
        else $error("lookup transfer did not start the exact scan");

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> ((CW+1)'(r_idx) <= (CW+1)'(r_cnt) + (CW+1)'(1)))
        else $error("scan index ran past the slot count");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_in_data.action == ACT_LOAD)) |=> (r_state == ST_IDLE))
        else $error("load transfer left the idle state");
`endif

endmodule

FILE: tb/ffts_checker.sv
// ffts_checker: watches the in, out and cfg channels of the fault fixup table search,
// predicts every lookup result from its own table copy and compares it with the block.
// Depends on ffts_pkg for the payload types and the action codes.
`timescale 1ns / 1ps

module ffts_checker
    import ffts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  t_out_item          i_out_data,
    input  logic               i_out_stall,
    input  logic               i_cfg_we,
    input  logic [SLOTS_W-1:0] i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    logic [ADDR_W-1:0]  insn_copy  [TABLE_DEPTH];
    logic [ADDR_W-1:0]  fixup_copy [TABLE_DEPTH];
    logic [SLOTS_W-1:0] search_count = '0;
    t_out_item          expected_results [$];
    int                 mismatches = 0;

    // Exact pass first (range pairs stepped over), then the range pass.
    function automatic t_out_item search_table(input logic [ADDR_W-1:0] addr);
        t_out_item         r;
        int                n;
        int                i;
        logic [ADDR_W-1:0] fix;
        logic [ADDR_W-1:0] delta;
        r = '0;
        n = (search_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(search_count);
        i = 0;
        while (i < n) begin
            if (fixup_copy[i] == '0) begin
                i += 2;
            end else if (insn_copy[i] == addr) begin
                r.found      = 1'b1;
                r.fixup_addr = fixup_copy[i];
                return r;
            end else begin
                i += 1;
            end
        end
        i = 0;
        while (i + 1 < n) begin
            if (fixup_copy[i] != '0) begin
                i += 1;
            end else if (insn_copy[i] <= addr && insn_copy[i + 1] > addr) begin
                fix           = fixup_copy[i + 1];
                delta         = addr - insn_copy[i];
                r.found       = (fix != '0);
                r.fixup_addr  = fix;
                r.range_hit   = 1'b1;
                r.insn_offset = OFFSET_W'(delta >> 2);
                return r;
            end else begin
                i += 2;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            search_count = '0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                search_count = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.action == ACT_LOAD) begin
                    if (int'(i_in_data.slot_index) < TABLE_DEPTH) begin
                        insn_copy[i_in_data.slot_index]  = i_in_data.slot_insn;
                        fixup_copy[i_in_data.slot_index] = i_in_data.slot_fixup;
                    end
                end else begin
                    expected_results.push_back(search_table(i_in_data.lookup_addr));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: found=%0b fixup=%h range=%0b offset=%h",
                                 got.found, got.fixup_addr, got.range_hit, got.insn_offset);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found || got.fixup_addr !== want.fixup_addr ||
                        got.range_hit !== want.range_hit ||
                        got.insn_offset !== want.insn_offset) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp found=%0b fixup=%h range=%0b offset=%h",
                                     want.found, want.fixup_addr, want.range_hit,
                                     want.insn_offset);
                            $display("          got found=%0b fixup=%h range=%0b offset=%h",
                                     got.found, got.fixup_addr, got.range_hit,
                                     got.insn_offset);
                        end
                    end
                end
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: tb/fault_fixup_table_search_tb.sv
// fault_fixup_table_search_tb: stimulus and verdict for the fault fixup table search.
// Depends on ffts_pkg, the block itself and ffts_checker, which does all prediction.
`timescale 1ns / 1ps

module fault_fixup_table_search_tb;
    import ffts_pkg::*;

    localparam int DEPTH = 256;
    // Longest quiet stretch of a correct run: one lookup over a full table,
    // plus a random receiver stall run.
    localparam int WATCHDOG_LIMIT = 4000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    t_in_item           in_data = '0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_data;
    logic               out_stall = 1'b0;
    logic               cfg_we = 1'b0;
    logic [SLOTS_W-1:0] cfg_data = '0;

    int fail_count;
    int pending;
    int items_sent = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // What the stimulus last loaded into each slot; used to aim lookups.
    logic [ADDR_W-1:0] shadow_insn [DEPTH] = '{default: '0};

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fault_fixup_table_search #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    ffts_checker #(
        .TABLE_DEPTH(DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Receiver back-pressure, one fresh draw per cycle.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: any transfer on any channel restarts the count.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ADDR_W-1:0] nonzero_fixup();
        logic [ADDR_W-1:0] f;
        f = rand64();
        return (f == '0) ? 64'd1 : f;
    endfunction

    // Addresses clustered around one region so that singles land inside
    // ranges and ranges overlap; some unaligned, some anywhere at all.
    function automatic logic [ADDR_W-1:0] near_addr(input logic [ADDR_W-1:0] region);
        logic [ADDR_W-1:0] a;
        if ($urandom_range(9) == 0) begin
            return rand64();
        end
        a = region + 64'(4 * $urandom_range(0, 1023));
        if ($urandom_range(7) == 0) begin
            a = a + 64'($urandom_range(1, 3));
        end
        return a;
    endfunction

    // Unused fields of an item carry random junk.
    function automatic t_in_item make_load(input logic [INDEX_W-1:0] idx,
                                           input logic [ADDR_W-1:0] insn,
                                           input logic [ADDR_W-1:0] fix);
        t_in_item it;
        it.action      = ACT_LOAD;
        it.slot_index  = idx;
        it.slot_insn   = insn;
        it.slot_fixup  = fix;
        it.lookup_addr = rand64();
        return it;
    endfunction

    function automatic t_in_item make_lookup(input logic [ADDR_W-1:0] addr);
        t_in_item it;
        it.action      = ACT_LOOKUP;
        it.slot_index  = INDEX_W'($urandom);
        it.slot_insn   = rand64();
        it.slot_fixup  = rand64();
        it.lookup_addr = addr;
        return it;
    endfunction

    // Table sizes: mostly tiny, now and then empty, full or past the depth.
    function automatic int pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 2) return DEPTH;
        if (r < 4) return $urandom_range(DEPTH + 1, 511);
        if (r < 10) return 0;
        if (r < 16) return 1;
        if (r < 22) return 2;
        return $urandom_range(3, 24);
    endfunction

    // One input transfer. Valid stays high from one item to the next unless
    // the sender decides to idle first. Stall is judged as it stands at the
    // edge, before the block updates it.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk iff !in_stall);
        items_sent++;
    endtask

    task automatic load_slot(input int idx, input logic [ADDR_W-1:0] insn,
                             input logic [ADDR_W-1:0] fix);
        shadow_insn[idx] = insn;
        send_item(make_load(INDEX_W'(idx), insn, fix));
    endtask

    // Hold off until every lookup result is back, then let a load that may
    // still be in flight settle. The first edge lets the pending count catch
    // up with a transfer taken at the current edge.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [SLOTS_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // One setting of slots_in_use: load every searched slot with a fresh
    // layout of singles and range pairs, then mix aimed lookups with loads
    // that overwrite slots and may break pairs apart.
    task automatic run_phase(input int count);
        int                span;
        int                slot;
        int                ops;
        int                op;
        int                idx;
        logic [ADDR_W-1:0] region;
        logic [ADDR_W-1:0] first;
        logic [ADDR_W-1:0] pick;
        logic [ADDR_W-1:0] addr;
        drain();
        write_count(SLOTS_W'(count));
        span   = (count > DEPTH) ? DEPTH : count;
        ops    = (span > 64) ? 8 : $urandom_range(10, 40);
        region = rand64() & ~64'hFFF;
        slot   = 0;
        while (slot < span) begin
            first = near_addr(region);
            if ($urandom_range(2) == 0) begin
                // range pair; a start landing in the last slot has no end
                load_slot(slot, first, '0);
                if (slot + 1 < span) begin
                    load_slot(slot + 1, first + 64'(4 * $urandom_range(1, 40)),
                              ($urandom_range(9) == 0) ? '0 : nonzero_fixup());
                end
                slot += 2;
            end else begin
                load_slot(slot, first, nonzero_fixup());
                slot += 1;
            end
        end
        for (op = 0; op < ops; op++) begin
            if ($urandom_range(99) < 2) begin
                drain();
            end
            if ($urandom_range(3) == 0) begin
                idx = (span > 0 && $urandom_range(1) == 1) ? $urandom_range(span - 1)
                                                           : $urandom_range(DEPTH - 1);
                load_slot(idx, near_addr(region),
                          ($urandom_range(2) == 0) ? '0 : nonzero_fixup());
            end else begin
                pick = (span > 0) ? shadow_insn[$urandom_range(span - 1)] : rand64();
                case ($urandom_range(7))
                    0, 1: begin
                        addr = pick;
                    end
                    2, 3: begin
                        addr = pick + 64'($urandom_range(0, 255));
                    end
                    4: begin
                        addr = pick - 64'd1;
                    end
                    5: begin
                        addr = rand64();
                    end
                    6: begin
                        addr = pick + 64'(4 * $urandom_range(0, 15));
                    end
                    default: begin
                        addr = ($urandom_range(1) == 1) ? '1 : '0;
                    end
                endcase
                send_item(make_lookup(addr));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 8;
        recv_idle_pct <= 62;

        // Directed: empty table, then a small hand-built one.
        write_count('0);
        send_item(make_lookup(64'h0));
        load_slot(0, 64'h0000_0000_0040_1010, 64'h0000_0000_0080_0000);  // single inside range
        load_slot(1, 64'h0000_0000_0040_1000, '0);                       // range start
        load_slot(2, 64'h0000_0000_0040_1040, 64'h0000_0000_0080_0100);  // range end
        load_slot(3, '1, '1);                                            // all-ones single
        load_slot(4, 64'h0000_0000_0040_2000, '0);                       // range start
        load_slot(5, 64'h0000_0000_0040_2010, '0);                       // end, zero fixup
        load_slot(6, 64'h0000_0000_0040_3000, '0);                       // start in last slot
        load_slot(DEPTH - 1, '0, 64'd1);                                 // top index, not searched
        drain();
        write_count(SLOTS_W'(7));
        send_item(make_lookup(64'h0000_0000_0040_1010));  // exact wins over range
        send_item(make_lookup(64'h0000_0000_0040_1000));  // first word of range
        send_item(make_lookup(64'h0000_0000_0040_103C));  // last word of range
        send_item(make_lookup(64'h0000_0000_0040_1040));  // end bound is exclusive
        send_item(make_lookup(64'h0000_0000_0040_1023));  // unaligned inside range
        send_item(make_lookup(64'h0000_0000_0040_2008));  // range with zero fixup
        send_item(make_lookup(64'h0000_0000_0040_3000));  // lone start is skipped
        send_item(make_lookup('1));                       // all-ones exact
        send_item(make_lookup('0));                       // no match
        send_item(make_lookup(64'h0000_0000_0040_0FFC));  // just below range

        // Random, busy sender and slow receiver.
        while (items_sent < 390) run_phase(pick_count());

        // Slow sender, busy receiver; count past the depth first.
        send_idle_pct = 62;
        recv_idle_pct <= 8;
        run_phase(511);
        while (items_sent < 780) run_phase(pick_count());

        // Back to back on both sides; full table first.
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        run_phase(DEPTH);
        while (items_sent < 1170) run_phase(pick_count());

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
